FILE: design/rau_pkg.sv
// Package for the rational arithmetic unit: payload structs, opcodes, status codes,
// sequencer states. No dependencies.
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_LT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
  } rau_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_CROSS,
    S_G_SHIFT,
    S_G_ODDX,
    S_G_ODDY,
    S_G_SUB,
    S_DIV_N,
    S_DIV_D,
    S_FIN,
    S_OUT
  } state_e;

  // Per-step control and status from the shared divider back to the sequencer.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

FILE: design/rau_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Does not depend on rau_pkg.
module rau_mul (
  input  logic        clk_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, x_i} * {32'd0, y_i};
  end
  assign p_o = p_q;
endmodule

FILE: design/rau_div.sv
// Restoring bit-serial 64-bit divider, one quotient bit per cycle.
// Depends on rau_pkg for div_ctl_t.
module rau_div
  import rau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dvd_i,
  input  logic [63:0] dvs_i,
  output div_ctl_t    ctl_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    trial = '0;
    if (start_i) begin
      quo_d = dvd_i;
      rem_d = '0;
      dvs_d = dvs_i;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // Busy only while bits remain; the quotient is final once the count is zero.
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = (cnt_q != 7'd0);
  assign quo_o       = quo_q;
endmodule

FILE: design/rational_arith_unit_top.sv
// Rational arithmetic unit: one item at a time. Decode, then three multiplies
// through one shared 32x32 multiplier, binary gcd over 64-bit values (one shift,
// test or subtract per cycle), then two divisions by the gcd through one
// bit-serial divider give the reduced result. Error items go straight to the
// output; zero and compare items skip the gcd and the divisions.
// in_ready_o is high only while idle; the result stays in the output register until
// taken, and the next item is accepted only after that. Depends on rau_pkg, rau_mul,
// rau_div.
module rational_arith_unit_top
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rau_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rau_out_t out_data_o
);
  localparam int W = OPERAND_WIDTH;

  state_e state_q, state_d;
  logic [2:0]  op_q;
  logic        an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [31:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic [63:0] t1_q, d_q, x_q, y_q, n_q;
  logic        t1_s_q, n_s_q;
  logic [6:0]  sh_q;
  rau_out_t    out_q;
  logic        out_v_q;

  logic [31:0] mx, my;
  logic [63:0] prod, dvd, dvs, quo;
  logic        div_start;
  div_ctl_t    dctl;

  rau_mul u_mul (.clk_i(clk_i), .x_i(mx), .y_i(my), .p_o(prod));
  rau_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .dvd_i(dvd),
                 .dvs_i(dvs), .ctl_o(dctl), .quo_o(quo));

  // Sign-magnitude of one field, low W bits sign-extended.
  function automatic logic [32:0] smag(input logic [31:0] raw);
    logic [31:0] v;
    logic        s;
    v = raw;
    s = raw[W-1];
    for (int i = W; i < 32; i++) v[i] = s;
    return {s, s ? 32'(-v) : v};
  endfunction

  logic [32:0] an, ad, bn, bd;
  assign an = smag(in_data_i.a_num);
  assign ad = smag(in_data_i.a_den);
  assign bn = smag(in_data_i.b_num);
  assign bd = smag(in_data_i.b_den);

  // Operand pairs fed to the multiplier per state.
  always_comb begin
    mx = an_m_q; my = bd_m_q;
    unique case (state_q)
      S_MUL1: begin
        mx = an_m_q;
        my = (op_q == OP_MUL) ? bn_m_q : bd_m_q;
      end
      S_MUL2: begin
        mx = ad_m_q;
        my = (op_q == OP_DIV) ? bn_m_q : bd_m_q;
      end
      S_MUL3: begin mx = bn_m_q; my = ad_m_q; end
      default: begin mx = an_m_q; my = bd_m_q; end
    endcase
  end

  logic [63:0] sum_m;
  logic        sum_s;
  logic        t2_s;
  logic        fin_ovf;
  logic [63:0] lim;
  assign lim = 64'd1 << (W - 1);

  // Cross-product sum; in S_CROSS the third product is on the multiplier output.
  always_comb begin
    t2_s = (prod != 64'd0) && (bn_s_q ^ ad_s_q ^ (op_q != OP_ADD));
    if (t1_s_q == t2_s) begin
      sum_m = t1_q + prod; sum_s = t1_s_q;
    end else if (t1_q >= prod) begin
      sum_m = t1_q - prod; sum_s = t1_s_q;
    end else begin
      sum_m = prod - t1_q; sum_s = t2_s;
    end
    if (sum_m == 64'd0) sum_s = 1'b0;
    sum_s = sum_s ^ ad_s_q ^ bd_s_q;
    if (sum_m == 64'd0) sum_s = 1'b0;
  end

  assign fin_ovf = (quo > lim - 64'd1) || (n_q > (n_s_q ? lim : lim - 64'd1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (ad[31:0] == 32'd0 || bd[31:0] == 32'd0 || in_data_i.operation > OP_LT ||
              (in_data_i.operation == OP_DIV && bn[31:0] == 32'd0)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_CROSS;
      S_CROSS: begin
        if (op_q == OP_LT) state_d = S_OUT;
        else if ((op_q == OP_MUL || op_q == OP_DIV) ? (t1_q == 64'd0) : (sum_m == 64'd0))
          state_d = S_OUT;
        else state_d = S_G_SHIFT;
      end
      S_G_SHIFT: if (x_q[0] || y_q[0]) state_d = S_G_ODDX;
      S_G_ODDX:  if (x_q[0]) state_d = S_G_ODDY;
      S_G_ODDY: begin
        if (y_q == 64'd0) state_d = S_DIV_N;
        else if (y_q[0]) state_d = S_G_SUB;
      end
      S_G_SUB: state_d = S_G_ODDY;
      S_DIV_N: if (!dctl.busy) state_d = S_DIV_D;
      S_DIV_D: if (!dctl.busy) state_d = S_FIN;
      S_FIN:   state_d = S_OUT;
      S_OUT:   if (out_v_q && out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath control.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign dvs = x_q << sh_q[5:0];
  assign dvd = (state_q == S_G_ODDY) ? n_q : d_q;
  assign div_start = (state_q == S_G_ODDY && y_q == 64'd0) ||
                     (state_q == S_DIV_N && !dctl.busy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      else if (state_q == S_OUT && !out_v_q) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q <= in_data_i.operation;
        {an_s_q, an_m_q} <= an; {ad_s_q, ad_m_q} <= ad;
        {bn_s_q, bn_m_q} <= bn; {bd_s_q, bd_m_q} <= bd;
        sh_q <= '0;
        if (ad[31:0] == 32'd0 || bd[31:0] == 32'd0)
          out_q <= '{status: ST_ZERO_DEN, res_num: 32'd0, res_den: 31'd0, is_less: 1'b0};
        else if (in_data_i.operation == OP_DIV && bn[31:0] == 32'd0)
          out_q <= '{status: ST_DIV_ZERO, res_num: 32'd0, res_den: 31'd0, is_less: 1'b0};
        else
          out_q <= '{status: ST_OK, res_num: 32'd0, res_den: 31'd1, is_less: 1'b0};
      end
      S_MUL2: begin
        t1_q <= prod;
        t1_s_q <= (prod != 64'd0) && (an_s_q ^ ((op_q == OP_MUL) ? bn_s_q : bd_s_q));
      end
      S_MUL3: d_q <= prod;
      S_CROSS: begin
        if (op_q == OP_MUL || op_q == OP_DIV) begin
          n_q <= t1_q; x_q <= t1_q; y_q <= d_q;
          n_s_q <= an_s_q ^ ((op_q == OP_MUL) ? bn_s_q : bd_s_q) ^ ad_s_q ^
                   ((op_q == OP_DIV) ? bn_s_q : bd_s_q);
          if (t1_q == 64'd0) out_q <= '{ST_OK, 32'd0, 31'd1, 1'b0};
        end else begin
          n_q <= sum_m; x_q <= sum_m; y_q <= d_q; n_s_q <= sum_s;
          if (op_q == OP_LT) out_q <= '{ST_OK, 32'd0, 31'd0, sum_s};
          else if (sum_m == 64'd0) out_q <= '{ST_OK, 32'd0, 31'd1, 1'b0};
        end
      end
      default: ;
    endcase
    unique case (state_q)
      S_G_SHIFT: begin
        if (!(x_q[0] || y_q[0])) begin
          x_q <= x_q >> 1; y_q <= y_q >> 1; sh_q <= sh_q + 7'd1;
        end
      end
      S_G_ODDX: if (!x_q[0]) x_q <= x_q >> 1;
      S_G_ODDY: if (y_q != 64'd0 && !y_q[0]) y_q <= y_q >> 1;
      S_G_SUB: begin
        if (x_q > y_q) begin x_q <= y_q; y_q <= x_q - y_q; end
        else y_q <= y_q - x_q;
      end
      S_DIV_N: if (!dctl.busy) n_q <= quo;
      S_FIN: begin
        if (fin_ovf)
          out_q <= '{status: ST_OVERFLOW, res_num: 32'd0, res_den: 31'd0, is_less: 1'b0};
        else
          out_q <= '{status: ST_OK,
                     res_num: n_s_q ? 32'(-n_q) : n_q[31:0],
                     res_den: quo[30:0], is_less: 1'b0};
      end
      default: ;
    endcase
  end

  logic unused;
  assign unused = dctl.start;
endmodule
